// ----- rtl/per_pixel_fade_in_out_engine_top_macros.svh -----
// assertion macros for the per-pixel fade engine checker
`ifndef PER_PIXEL_FADE_IN_OUT_ENGINE_TOP_MACROS_SVH
`define PER_PIXEL_FADE_IN_OUT_ENGINE_TOP_MACROS_SVH

// consequent checked in the same cycle
`define PPFE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the next cycle
`define PPFE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ppfe_pkg.sv -----
// shared constants, types and arithmetic helpers of the per-pixel fade engine
package ppfe_pkg;

   localparam int PIXEL_COUNT = 256;
   localparam int ADDR_W      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

   localparam int IDX_W      = 8;
   localparam int COLOR_W    = 8;
   localparam int STEP_W     = 8;
   localparam int CHAN_N     = 3;
   localparam int REQ_DATA_W = IDX_W + CHAN_N * COLOR_W;
   localparam int RSP_DATA_W = IDX_W + CHAN_N * COLOR_W;
   localparam int PROD_W     = STEP_W + COLOR_W;
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = PROD_W / DIV_BITS;

   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = FIFO_AW + 1;

   localparam logic [STEP_W-1:0]  FADE_STEPS_RESET = 8'd80;
   localparam logic [COLOR_W:0]   CHAN_MOD         = 9'd255;

   typedef logic [CHAN_N-1:0][COLOR_W-1:0] color_type;
   typedef logic [CHAN_N-1:0][PROD_W-1:0]  prod_type;
   typedef logic [CHAN_N-1:0][STEP_W-1:0]  rem_type;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic              rising;
   } pix_state_type;

   typedef struct packed {
      color_type         color;
      logic              write;
      logic [IDX_W-1:0]  index;
   } rsp_type;

   // DIV_BITS quotient bits of a restoring division, msb first
   function automatic logic [STEP_W+DIV_BITS-1:0] div_step(
      input logic [STEP_W-1:0]   rem,
      input logic [DIV_BITS-1:0] bits,
      input logic [STEP_W-1:0]   divisor
   );
      logic [STEP_W:0]       trial;
      logic [STEP_W-1:0]     r;
      logic [DIV_BITS-1:0]   q;
      r = rem;
      q = '0;
      for (int i = DIV_BITS - 1; i >= 0; i--) begin
         trial = {r, bits[i]};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
            q[i]  = 1'b1;
         end
         r = trial[STEP_W-1:0];
      end
      return {r, q};
   endfunction

   // value mod 255 via high byte plus low byte
   function automatic logic [COLOR_W-1:0] mod_255(input logic [PROD_W-1:0] value);
      logic [COLOR_W:0] s;
      s = {1'b0, value[PROD_W-1:COLOR_W]} + {1'b0, value[COLOR_W-1:0]};
      if (s >= CHAN_MOD) begin
         s = s - CHAN_MOD;
      end
      return s[COLOR_W-1:0];
   endfunction

endpackage

// ----- rtl/per_pixel_fade_in_out_engine_top.sv -----
// per-pixel fade engine: state memories, scaling pipeline and output queue
//
// Takes one pixel visit per clock while req_tready is high and returns one word
// per visit, in order. The fade step and direction live in one memory and the
// target colors in another, both read when the visit is accepted and written
// back in the next cycle; a visit to the same pixel in the very next cycle gets
// the written values forwarded. Color scaling is an 8x8 multiply followed by a
// four-stage divider (four quotient bits per stage) and a mod-255 fold, after
// which each word is pushed into the output queue. The 16-word output queue
// keeps accepting visits while results wait; req_tready drops only when 16
// words are in flight or queued. Reset clears the step and direction of every
// pixel at once; no clearing pass is needed.
module per_pixel_fade_in_out_engine_top
   import ppfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // pixel_index, new_red, new_green, new_blue
   input  logic [0:0]            req_tuser,   // start_request
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_index, out_red, out_green, out_blue
   output logic [0:0]            rsp_tuser,   // pixel_write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [STEP_W-1:0]     csr_wdata
);

   logic [STEP_W-1:0] fade_steps_ff;
   logic [STEP_W-1:0] div_w;

   logic              req_accept;
   logic [IDX_W-1:0]  req_idx;
   logic [ADDR_W-1:0] req_addr;
   logic              req_in_range;
   color_type         req_color;

   pix_state_type     state_mem [PIXEL_COUNT];
   color_type         color_mem [PIXEL_COUNT];
   logic [PIXEL_COUNT-1:0] state_valid_ff;
   pix_state_type     state_rd_ff;
   color_type         color_rd_ff;
   logic              rd_valid_ff;

   logic              fwd_state_hit_ff;
   logic              fwd_color_hit_ff;
   pix_state_type     fwd_state_ff;
   color_type         fwd_color_ff;

   logic              s1_v_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              s1_in_range_ff;
   logic              s1_start_ff;
   color_type         s1_color_ff;

   pix_state_type     cur_state;
   color_type         cur_color;
   logic              active;
   logic              start_load;
   logic              rising_in;
   logic [STEP_W-1:0] step_in;
   logic              state_we;
   logic              color_we;
   pix_state_type     wr_state;
   prod_type          prod_in;

   logic              s2_v_ff;
   logic [IDX_W-1:0]  s2_idx_ff;
   logic              s2_write_ff;
   logic              s2_black_ff;
   prod_type          s2_prod_ff;

   logic              dv_v_ff     [DIV_STAGES];
   logic [IDX_W-1:0]  dv_idx_ff   [DIV_STAGES];
   logic              dv_write_ff [DIV_STAGES];
   logic              dv_black_ff [DIV_STAGES];
   rem_type           dv_rem_ff   [DIV_STAGES];
   prod_type          dv_quo_ff   [DIV_STAGES];
   rem_type           dv_src_rem  [DIV_STAGES];
   prod_type          dv_src_quo  [DIV_STAGES];
   rem_type           dv_rem_in   [DIV_STAGES];
   prod_type          dv_quo_in   [DIV_STAGES];

   logic              push;
   rsp_type           push_word;
   logic              pop;
   rsp_type           fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff;
   logic [FIFO_AW-1:0] rd_ptr_ff;
   logic [CNT_W-1:0]  fifo_cnt_ff;
   logic [CNT_W-1:0]  fifo_cnt_in;
   logic [CNT_W-1:0]  credit_ff;
   logic [CNT_W-1:0]  credit_in;
   rsp_type           rsp_word;

   // configuration
   assign csr_ready = 1'b1;
   assign div_w     = (fade_steps_ff == '0) ? STEP_W'(1) : fade_steps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_steps_ff <= FADE_STEPS_RESET;
      end else if (csr_valid && csr_ready) begin
         fade_steps_ff <= csr_wdata;
      end
   end

   // input side
   assign req_accept   = req_tvalid && req_tready;
   assign req_idx      = req_tdata[IDX_W-1:0];
   assign req_color    = req_tdata[REQ_DATA_W-1:IDX_W];
   assign req_addr     = ADDR_W'(req_idx);
   assign req_in_range = (32'(req_idx) < 32'(PIXEL_COUNT));
   assign req_tready   = (credit_ff < CNT_W'(FIFO_DEPTH));

   // state memories
   always_ff @(posedge clock) begin
      if (state_we) begin
         state_mem[s1_addr_ff] <= wr_state;
      end
      if (color_we) begin
         color_mem[s1_addr_ff] <= s1_color_ff;
      end
      state_rd_ff  <= state_mem[req_addr];
      color_rd_ff  <= color_mem[req_addr];
      rd_valid_ff  <= state_valid_ff[req_addr];
      fwd_state_ff <= wr_state;
      fwd_color_ff <= s1_color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_valid_ff   <= '0;
         fwd_state_hit_ff <= 1'b0;
         fwd_color_hit_ff <= 1'b0;
      end else begin
         if (state_we) begin
            state_valid_ff[s1_addr_ff] <= 1'b1;
         end
         fwd_state_hit_ff <= state_we && req_accept && (req_addr == s1_addr_ff);
         fwd_color_hit_ff <= color_we && req_accept && (req_addr == s1_addr_ff);
      end
   end

   // stage 1: read-modify-write of the pixel state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff      <= req_idx;
      s1_addr_ff     <= req_addr;
      s1_in_range_ff <= req_in_range;
      s1_start_ff    <= req_tuser[0];
      s1_color_ff    <= req_color;
   end

   always_comb begin
      if (fwd_state_hit_ff) begin
         cur_state = fwd_state_ff;
      end else if (rd_valid_ff) begin
         cur_state = state_rd_ff;
      end else begin
         cur_state = '0;
      end
      cur_color  = fwd_color_hit_ff ? fwd_color_ff : color_rd_ff;
      active     = s1_in_range_ff && (cur_state.step != '0);
      start_load = s1_in_range_ff && !active && s1_start_ff;
      rising_in  = (cur_state.step >= div_w) ? 1'b0 : cur_state.rising;
      step_in    = rising_in ? cur_state.step + STEP_W'(1) : cur_state.step - STEP_W'(1);
      state_we   = s1_v_ff && (active || start_load);
      color_we   = s1_v_ff && start_load;
      wr_state.step   = active ? step_in : STEP_W'(1);
      wr_state.rising = active ? rising_in : 1'b1;
      for (int c = 0; c < CHAN_N; c++) begin
         prod_in[c] = PROD_W'(cur_state.step) * PROD_W'(cur_color[c]);
      end
   end

   // stage 2: products
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_idx_ff   <= s1_idx_ff;
      s2_write_ff <= active;
      s2_black_ff <= (step_in == '0);
      s2_prod_ff  <= prod_in;
   end

   // divider stages
   always_comb begin
      logic [STEP_W+DIV_BITS-1:0] res;
      dv_src_rem[0] = '0;
      dv_src_quo[0] = s2_prod_ff;
      for (int k = 1; k < DIV_STAGES; k++) begin
         dv_src_rem[k] = dv_rem_ff[k-1];
         dv_src_quo[k] = dv_quo_ff[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         for (int c = 0; c < CHAN_N; c++) begin
            res = div_step(dv_src_rem[k][c], dv_src_quo[k][c][PROD_W-1 -: DIV_BITS], div_w);
            dv_rem_in[k][c] = res[STEP_W+DIV_BITS-1:DIV_BITS];
            dv_quo_in[k][c] = {dv_src_quo[k][c][PROD_W-DIV_BITS-1:0], res[DIV_BITS-1:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            dv_v_ff[k] <= 1'b0;
         end
      end else begin
         dv_v_ff[0] <= s2_v_ff;
         for (int k = 1; k < DIV_STAGES; k++) begin
            dv_v_ff[k] <= dv_v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      dv_idx_ff[0]   <= s2_idx_ff;
      dv_write_ff[0] <= s2_write_ff;
      dv_black_ff[0] <= s2_black_ff;
      for (int k = 1; k < DIV_STAGES; k++) begin
         dv_idx_ff[k]   <= dv_idx_ff[k-1];
         dv_write_ff[k] <= dv_write_ff[k-1];
         dv_black_ff[k] <= dv_black_ff[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         dv_rem_ff[k] <= dv_rem_in[k];
         dv_quo_ff[k] <= dv_quo_in[k];
      end
   end

   // mod 255 and output queue
   always_comb begin
      push            = dv_v_ff[DIV_STAGES-1];
      push_word.index = dv_idx_ff[DIV_STAGES-1];
      push_word.write = dv_write_ff[DIV_STAGES-1];
      for (int c = 0; c < CHAN_N; c++) begin
         if (dv_write_ff[DIV_STAGES-1] && !dv_black_ff[DIV_STAGES-1]) begin
            push_word.color[c] = mod_255(dv_quo_ff[DIV_STAGES-1][c]);
         end else begin
            push_word.color[c] = '0;
         end
      end
   end

   assign pop      = rsp_tvalid && rsp_tready;
   assign rsp_word = fifo_mem[rd_ptr_ff];

   always_comb begin
      case ({push, pop})
         2'b10:   fifo_cnt_in = fifo_cnt_ff + CNT_W'(1);
         2'b01:   fifo_cnt_in = fifo_cnt_ff - CNT_W'(1);
         default: fifo_cnt_in = fifo_cnt_ff;
      endcase
      case ({req_accept, pop})
         2'b10:   credit_in = credit_ff + CNT_W'(1);
         2'b01:   credit_in = credit_ff - CNT_W'(1);
         default: credit_in = credit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         credit_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
         fifo_cnt_ff <= fifo_cnt_in;
         credit_ff   <= credit_in;
      end
   end

   assign rsp_tvalid = (fifo_cnt_ff != '0);
   assign rsp_tdata  = {rsp_word.color, rsp_word.index};
   assign rsp_tuser  = rsp_word.write;

endmodule

// ----- rtl/ppfe_checker.sv -----
// port-level checker of the per-pixel fade engine and its bind
`include "per_pixel_fade_in_out_engine_top_macros.svh"

module ppfe_checker
   import ppfe_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,   // out_index, out_red, out_green, out_blue
   input logic [0:0]            rsp_tuser    // pixel_write
);

   logic [CHAN_N-1:0][COLOR_W-1:0] rsp_color;
   assign rsp_color = rsp_tdata[RSP_DATA_W-1:IDX_W];

   `PPFE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response word changed while stalled")

   `PPFE_ASSERT_SAME(a_no_write_black, rsp_tvalid && !rsp_tuser[0], rsp_color == '0, "color on a word without pixel write")

   `PPFE_ASSERT_SAME(a_color_range, rsp_tvalid && rsp_tuser[0], (rsp_color[0] != 8'hFF) && (rsp_color[1] != 8'hFF) && (rsp_color[2] != 8'hFF), "color component above 254")

endmodule

bind per_pixel_fade_in_out_engine_top ppfe_checker u_ppfe_checker (.*);

// ----- tb/sv/per_pixel_fade_in_out_engine_top_tb.sv -----
// testbench of the per-pixel fade engine: predicts every pixel word and checks the result stream
module per_pixel_fade_in_out_engine_top_tb;
   import ppfe_pkg::*;

   localparam int RED_LSB        = IDX_W;
   localparam int GREEN_LSB      = IDX_W + COLOR_W;
   localparam int BLUE_LSB       = IDX_W + 2 * COLOR_W;
   localparam int COLOR_MOD      = 255;
   localparam int MAX_WAIT       = 17;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      logic [IDX_W-1:0]   index;
      logic               write;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pixel_word_type;

   class pixel_fade_tracker;
      logic [STEP_W-1:0]  fade_steps;
      logic [STEP_W-1:0]  step_mem [PIXEL_COUNT];
      logic               rising_mem [PIXEL_COUNT];
      logic [COLOR_W-1:0] red_mem [PIXEL_COUNT];
      logic [COLOR_W-1:0] green_mem [PIXEL_COUNT];
      logic [COLOR_W-1:0] blue_mem [PIXEL_COUNT];
      pixel_word_type     pending_words [$];
      int                 errors;

      function new();
         fade_steps = FADE_STEPS_RESET;
         errors     = 0;
         foreach (step_mem[i]) begin
            step_mem[i]   = '0;
            rising_mem[i] = 1'b0;
            red_mem[i]    = '0;
            green_mem[i]  = '0;
            blue_mem[i]   = '0;
         end
      endfunction

      function void set_fade(input logic [STEP_W-1:0] value);
         fade_steps = value;
      endfunction

      function logic [COLOR_W-1:0] scale(input int unsigned step, input int unsigned comp,
                                         input int unsigned div);
         return COLOR_W'(((step * comp) / div) % COLOR_MOD);
      endfunction

      function void note_visit(input logic [IDX_W-1:0] index, input logic start,
                               input logic [COLOR_W-1:0] red, input logic [COLOR_W-1:0] green,
                               input logic [COLOR_W-1:0] blue);
         pixel_word_type word;
         int unsigned step;
         int unsigned div;
         div        = (fade_steps == 0) ? 1 : fade_steps;
         word.index = index;
         word.write = 1'b0;
         word.red   = '0;
         word.green = '0;
         word.blue  = '0;
         if (int'(index) < PIXEL_COUNT) begin
            step = step_mem[index];
            if (step > 0) begin
               word.write = 1'b1;
               word.red   = scale(step, red_mem[index], div);
               word.green = scale(step, green_mem[index], div);
               word.blue  = scale(step, blue_mem[index], div);
               if (step >= div) begin
                  rising_mem[index] = 1'b0;
               end
               step = rising_mem[index] ? step + 1 : step - 1;
               step_mem[index] = STEP_W'(step);
               // fade finished: pixel goes black
               if (step_mem[index] == 0) begin
                  word.red   = '0;
                  word.green = '0;
                  word.blue  = '0;
               end
            end else if (start) begin
               red_mem[index]    = red;
               green_mem[index]  = green;
               blue_mem[index]   = blue;
               step_mem[index]   = 1;
               rising_mem[index] = 1'b1;
            end
         end
         pending_words.push_back(word);
      endfunction

      function void compare_field(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
         if (got !== want) begin
            $error("%s expected %0d actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_word(input pixel_word_type got);
         pixel_word_type want;
         if (pending_words.size() == 0) begin
            $error("word for pixel %0d with none expected", got.index);
            errors++;
            return;
         end
         want = pending_words.pop_front();
         compare_field("out_index", want.index, got.index);
         compare_field("pixel_write", 8'(want.write), 8'(got.write));
         compare_field("out_red", want.red, got.red);
         compare_field("out_green", want.green, got.green);
         compare_field("out_blue", want.blue, got.blue);
      endfunction

      function int pending();
         return pending_words.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [STEP_W-1:0]     csr_wdata = '0;

   pixel_fade_tracker tracker = new();
   pixel_word_type    got_word;
   bit                req_no_gap = 1'b0;
   bit                rsp_no_stall = 1'b0;
   int                pool_base = 0;
   int                idle_cycles = 0;

   per_pixel_fade_in_out_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            tracker.set_fade(csr_wdata);
         end
         if (req_tvalid && req_tready) begin
            tracker.note_visit(req_tdata[IDX_W-1:0], req_tuser[0],
                               req_tdata[RED_LSB +: COLOR_W], req_tdata[GREEN_LSB +: COLOR_W],
                               req_tdata[BLUE_LSB +: COLOR_W]);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_word.index = rsp_tdata[IDX_W-1:0];
            got_word.write = rsp_tuser[0];
            got_word.red   = rsp_tdata[RED_LSB +: COLOR_W];
            got_word.green = rsp_tdata[GREEN_LSB +: COLOR_W];
            got_word.blue  = rsp_tdata[BLUE_LSB +: COLOR_W];
            tracker.check_word(got_word);
         end
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready)
             || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[per_pixel_fade_in_out_engine_top] ERROR");
            $finish;
         end
      end
   end

   // result side: random stall before each word unless rsp_no_stall is set
   initial begin : rsp_sink
      int stall;
      forever begin
         @(negedge clock);
         stall = rsp_no_stall ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   task automatic send_visit(input logic [IDX_W-1:0] index, input logic start,
                             input logic [COLOR_W-1:0] red, input logic [COLOR_W-1:0] green,
                             input logic [COLOR_W-1:0] blue);
      int gap;
      gap = req_no_gap ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {blue, green, red, index};
      req_tuser  <= start;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending() > 0) @(negedge clock);
   endtask

   task automatic write_fade_steps(input logic [STEP_W-1:0] value);
      drain_results();
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [COLOR_W-1:0] pick_color();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return COLOR_W'($urandom_range(0, 255));
      endcase
   endfunction

   // fades on a small pool of pixels, with an occasional visit to a random pixel, so that they run to the top and back
   task automatic run_fades(input int fade, input int words, input int pool, input bit keep_base);
      logic [IDX_W-1:0] index;
      write_fade_steps(STEP_W'(fade));
      if (!keep_base) begin
         pool_base = $urandom_range(0, 255);
      end
      req_no_gap   = ($urandom_range(0, 3) == 0);
      rsp_no_stall = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < words; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            index = IDX_W'($urandom_range(0, 255));
         end else begin
            index = IDX_W'(pool_base + $urandom_range(0, pool - 1));
         end
         send_visit(index, $urandom_range(0, 9) != 0, pick_color(), pick_color(), pick_color());
         if ($urandom_range(0, 59) == 0) begin
            drain_results();
         end
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      send_visit(8'd0, 1'b1, 8'hFF, 8'hFF, 8'hFF);
      send_visit(8'd255, 1'b1, 8'h00, 8'h00, 8'h00);
      send_visit(8'd1, 1'b1, 8'd200, 8'd100, 8'd37);
      send_visit(8'd7, 1'b0, 8'hAA, 8'h55, 8'hAA);
      send_visit(8'd0, 1'b1, 8'd1, 8'd2, 8'd3);
      send_visit(8'd255, 1'b0, 8'h00, 8'h00, 8'h00);
      send_visit(8'd1, 1'b0, 8'h00, 8'h00, 8'h00);
      drain_results();
      // lower the step count while pixels are mid-fade
      write_fade_steps(8'd1);
      send_visit(8'd1, 1'b0, 8'h00, 8'h00, 8'h00);
      send_visit(8'd0, 1'b0, 8'h00, 8'h00, 8'h00);
      send_visit(8'd1, 1'b0, 8'h00, 8'h00, 8'h00);
      send_visit(8'd1, 1'b1, 8'hFF, 8'h80, 8'h7F);
      send_visit(8'd1, 1'b0, 8'h00, 8'h00, 8'h00);
      write_fade_steps(8'd0);
      send_visit(8'd0, 1'b0, 8'h00, 8'h00, 8'h00);
      send_visit(8'd255, 1'b0, 8'h00, 8'h00, 8'h00);
      send_visit(8'd0, 1'b0, 8'h00, 8'h00, 8'h00);
      send_visit(8'd255, 1'b1, 8'h00, 8'h00, 8'h00);

      run_fades(255, 340, 2, 1'b0);
      run_fades(2, 60, 2, 1'b1);
      run_fades(0, 60, 4, 1'b0);
      run_fades(1, 60, 4, 1'b1);
      run_fades($urandom_range(3, 20), 100, 6, 1'b0);
      run_fades(128, 100, 1, 1'b0);
      run_fades($urandom_range(1, 255), 100, 8, 1'b0);
      run_fades(80, 40, 8, 1'b1);

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("[per_pixel_fade_in_out_engine_top] OK");
      end else begin
         $display("[per_pixel_fade_in_out_engine_top] ERROR");
      end
      $finish;
   end

endmodule
